@@ sv/tdc_rtd_pkg.sv @@
// shared widths, constants, codes and types of the rtd temperature pipeline
`timescale 1ns / 1ps
package tdc_rtd_pkg;

  localparam int FINE_BITS       = 23;
  localparam int COARSE_BITS     = 16;
  localparam int RATIO_FRAC_BITS = 32;

  localparam int CP_W      = 6;
  localparam int CLK_W     = 20;
  localparam int RREF_W    = 27;
  localparam int ALPHA_W   = 14;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 2;

  localparam int PD_W   = FINE_BITS + CLK_W;
  localparam int N_W    = PD_W + CP_W;
  localparam int CC_W   = COARSE_BITS + CLK_W;
  localparam int TOF_W  = ((N_W > CC_W) ? N_W : CC_W) + 3;
  localparam int IV_W   = TOF_W + 1;
  localparam int DV_W   = TOF_W;
  localparam int A_W    = TOF_W;
  localparam int RMAG_W = 63;
  localparam int SAT_SH = RMAG_W - RATIO_FRAC_BITS;
  localparam int M_W    = RMAG_W + 1;
  localparam int BIG_SH = RATIO_FRAC_BITS + 14;
  localparam int ML_W   = BIG_SH / 2;
  localparam int MH_W   = BIG_SH - ML_W;
  localparam int DECI_W = 24;
  localparam int S_W    = BIG_SH + DECI_W - (RATIO_FRAC_BITS - 1);
  localparam int PR_W   = RMAG_W + RREF_W + 1;

  localparam int OTOF_W  = 33;
  localparam int RTD_W   = 27;
  localparam int TEMP_W  = 15;
  localparam int ERR_W   = 2;
  localparam int IN_W    = 6 * FINE_BITS + 3 * COARSE_BITS;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 2 * OTOF_W + RTD_W + TEMP_W + ERR_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  localparam logic [OTOF_W-1:0] TOF_MAX      = 33'd6553600000;
  localparam logic [RTD_W-1:0]  RTD_MAX      = 27'd100000000;
  localparam int                TEMP_HI      = 8500;
  localparam int                TEMP_LO      = 2000;
  localparam logic [DECI_W-1:0] DECI_PER_PPM = 24'd10000000;

  localparam logic [CP_W-1:0]    CAL_PERIODS_RST = 6'd10;
  localparam logic [CLK_W-1:0]   CLOCK_PS_RST    = 20'd100000;
  localparam logic [RREF_W-1:0]  REF_RES_RST     = 27'd1000000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 14'd3850;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_SPAN = 2'd1,
    ERR_IV   = 2'd2
  } error_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_PERIODS = 2'd0,
    REG_CLOCK_PS    = 2'd1,
    REG_REF_RES     = 2'd2,
    REG_ALPHA       = 2'd3
  } cfg_reg_e;

  // lane 0 stop1, lane 1 stop4, lane 2 stop5
  typedef struct packed {
    logic [FINE_BITS-1:0]        start;
    logic [2:0][FINE_BITS-1:0]   stop_fine;
    logic [2:0][COARSE_BITS-1:0] coarse;
    logic [FINE_BITS-1:0]        cal_first;
    logic [FINE_BITS-1:0]        cal_second;
  } meas_t;

  typedef struct packed {
    logic                    err_span;
    logic signed [TOF_W-1:0] t1;
    logic signed [TOF_W-1:0] t4;
    logic signed [TOF_W-1:0] t5;
  } tof_t;

  typedef struct packed {
    error_e            err;
    logic [OTOF_W-1:0] tof_ref;
    logic [OTOF_W-1:0] tof_stop5;
    logic              rneg;
    logic [RTD_W-1:0]  rtd;
    logic              tneg;
    logic              big;
    logic              mzero;
  } side_t;

endpackage

@@ sv/tdc_rtd_temperature_compute.sv @@
// rtd temperature from converter readings: top level, ratio and temperature stages
`timescale 1ns / 1ps
// Usage: one measurement set enters on the s_axis channel per accepted item and
// one result leaves on the m_axis channel, in order. Registers are written on
// the cfg port (cal_periods, clock_period_ps, ref_resistance_milliohm,
// alpha_ppm) by the user only while no item is in flight (not enforced by the
// block); they take effect for later items. 53 stages build the three times of
// flight (a 49-stage bit-per-cycle divider shared by the three lanes), 65
// stages form the Q32 ratio (63-stage divider), three stages do the resistance
// and scaling multiplies and 40 stages divide by alpha. Throughput is one item
// per cycle unless stalled: every stage is a register with a valid bit. Reset
// clears every valid bit and restores the register defaults; the output is
// empty after reset. When the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline freezes and s_axis_tready drops in the same
// cycle; nothing is lost or repeated, and bubbles in flight are kept as they
// are. Error code 1 (calibration span zero) zeroes all other fields; error code
// 2 (rtd interval not positive) keeps both times of flight and zeroes the rest.
module tdc_rtd_temperature_compute (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_fine, stop1_fine, stop4_fine, stop5_fine, stop1_coarse, stop4_coarse,
  // stop5_coarse, cal_first, cal_second, zero fill
  input  logic [tdc_rtd_pkg::IN_TW-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tof_ref_ps, tof_stop5_ps, rtd_milliohm, temp_decidegc, error_code, zero fill
  output logic [tdc_rtd_pkg::OUT_TW-1:0]      m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tdc_rtd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tdc_rtd_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int FB      = tdc_rtd_pkg::FINE_BITS;
  localparam int CB      = tdc_rtd_pkg::COARSE_BITS;
  localparam int RF      = tdc_rtd_pkg::RATIO_FRAC_BITS;
  localparam int CP_W    = tdc_rtd_pkg::CP_W;
  localparam int CLK_W   = tdc_rtd_pkg::CLK_W;
  localparam int RREF_W  = tdc_rtd_pkg::RREF_W;
  localparam int ALPHA_W = tdc_rtd_pkg::ALPHA_W;
  localparam int TOF_W   = tdc_rtd_pkg::TOF_W;
  localparam int IV_W    = tdc_rtd_pkg::IV_W;
  localparam int DV_W    = tdc_rtd_pkg::DV_W;
  localparam int A_W     = tdc_rtd_pkg::A_W;
  localparam int RMAG_W  = tdc_rtd_pkg::RMAG_W;
  localparam int SAT_SH  = tdc_rtd_pkg::SAT_SH;
  localparam int M_W     = tdc_rtd_pkg::M_W;
  localparam int BIG_SH  = tdc_rtd_pkg::BIG_SH;
  localparam int ML_W    = tdc_rtd_pkg::ML_W;
  localparam int MH_W    = tdc_rtd_pkg::MH_W;
  localparam int DECI_W  = tdc_rtd_pkg::DECI_W;
  localparam int S_W     = tdc_rtd_pkg::S_W;
  localparam int PR_W    = tdc_rtd_pkg::PR_W;
  localparam int OTOF_W  = tdc_rtd_pkg::OTOF_W;
  localparam int RTD_W   = tdc_rtd_pkg::RTD_W;
  localparam int TEMP_W  = tdc_rtd_pkg::TEMP_W;
  localparam int OUT_W   = tdc_rtd_pkg::OUT_W;
  localparam int OUT_TW  = tdc_rtd_pkg::OUT_TW;

  // configuration registers
  logic [CP_W-1:0]    cal_periods_q;
  logic [CLK_W-1:0]   clock_ps_q;
  logic [RREF_W-1:0]  ref_res_q;
  logic [ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_periods_q <= tdc_rtd_pkg::CAL_PERIODS_RST;
      clock_ps_q    <= tdc_rtd_pkg::CLOCK_PS_RST;
      ref_res_q     <= tdc_rtd_pkg::REF_RES_RST;
      alpha_q       <= tdc_rtd_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      unique case (tdc_rtd_pkg::cfg_reg_e'(cfg_index_i))
        tdc_rtd_pkg::REG_CAL_PERIODS: cal_periods_q <= cfg_data_i[CP_W-1:0];
        tdc_rtd_pkg::REG_CLOCK_PS:    clock_ps_q    <= cfg_data_i[CLK_W-1:0];
        tdc_rtd_pkg::REG_REF_RES:     ref_res_q     <= cfg_data_i[RREF_W-1:0];
        tdc_rtd_pkg::REG_ALPHA:       alpha_q       <= cfg_data_i[ALPHA_W-1:0];
        default:                      cal_periods_q <= cal_periods_q;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result sits unaccepted
  logic en;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  tdc_rtd_pkg::meas_t meas;

  always_comb begin
    meas.start = s_axis_tdata[FB-1:0];
    for (int l = 0; l < 3; l++) begin
      meas.stop_fine[l] = s_axis_tdata[(l + 1) * FB +: FB];
      meas.coarse[l]    = s_axis_tdata[4 * FB + l * CB +: CB];
    end
    meas.cal_first  = s_axis_tdata[4 * FB + 3 * CB +: FB];
    meas.cal_second = s_axis_tdata[5 * FB + 3 * CB +: FB];
  end

  logic              tof_v;
  tdc_rtd_pkg::tof_t tof;

  tdc_rtd_tof u_tof (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s_axis_tvalid),
    .meas_i         (meas),
    .cal_periods_i  (cal_periods_q),
    .clock_period_i (clock_ps_q),
    .valid_o        (tof_v),
    .tof_o          (tof)
  );

  // stage f: interval, magnitude of tof1, saturated outputs, error code
  logic signed [IV_W-1:0] iv_d;
  logic [A_W-1:0]         a_d;
  tdc_rtd_pkg::side_t     side_d;

  function automatic logic [OTOF_W-1:0] sat_tof(input logic signed [TOF_W-1:0] t);
    logic [OTOF_W-1:0] r;
    if (t < 0) r = '0;
    else if (TOF_W'(t) > TOF_W'(tdc_rtd_pkg::TOF_MAX)) r = tdc_rtd_pkg::TOF_MAX;
    else r = t[OTOF_W-1:0];
    return r;
  endfunction

  always_comb begin
    iv_d             = IV_W'(tof.t5) - IV_W'(tof.t4);
    a_d              = tof.t1[TOF_W-1] ? A_W'(-tof.t1) : A_W'(tof.t1);
    side_d           = '0;
    side_d.tof_ref   = sat_tof(tof.t1);
    side_d.tof_stop5 = sat_tof(tof.t5);
    side_d.rneg      = tof.t1[TOF_W-1];
    if (tof.err_span) side_d.err = tdc_rtd_pkg::ERR_SPAN;
    else if (iv_d <= 0) side_d.err = tdc_rtd_pkg::ERR_IV;
    else side_d.err = tdc_rtd_pkg::ERR_OK;
  end

  logic                   vf_q;
  logic signed [IV_W-1:0] iv_f_q;
  logic [A_W-1:0]         a_f_q;
  tdc_rtd_pkg::side_t     side_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en) vf_q <= tof_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      iv_f_q   <= iv_d;
      a_f_q    <= a_d;
      side_f_q <= side_d;
    end
  end

  // ratio divider: index 0 loads, then one quotient bit per stage
  logic [RMAG_W-1:0]  rpack_q [RMAG_W+1];
  logic [DV_W-1:0]    rrem_q  [RMAG_W+1];
  logic [DV_W-1:0]    rdiv_q  [RMAG_W+1];
  logic               rsat_q  [RMAG_W+1];
  tdc_rtd_pkg::side_t rside_q [RMAG_W+1];
  logic               rv_q    [RMAG_W+1];

  logic [DV_W-1:0]     a_hi;
  logic [A_W+RF-1:0]   a_wide;
  logic                sat_d;

  always_comb begin
    a_hi   = DV_W'(a_f_q >> SAT_SH);
    a_wide = {a_f_q, {RF{1'b0}}};
    // ratio of 2^(63-frac) or more saturates
    sat_d  = a_hi >= iv_f_q[DV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[0] <= 1'b0;
    else if (en) rv_q[0] <= vf_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rpack_q[0] <= a_wide[RMAG_W-1:0];
      rrem_q[0]  <= sat_d ? '0 : a_hi;
      rdiv_q[0]  <= iv_f_q[DV_W-1:0];
      rsat_q[0]  <= sat_d;
      rside_q[0] <= side_f_q;
    end
  end

  for (genvar g = 1; g <= RMAG_W; g++) begin : g_rdiv
    logic [DV_W:0] trial;
    logic          ge;

    assign trial = {rrem_q[g-1], rpack_q[g-1][RMAG_W-1]};
    assign ge    = trial >= {1'b0, rdiv_q[g-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[g] <= 1'b0;
      else if (en) rv_q[g] <= rv_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rpack_q[g] <= {rpack_q[g-1][RMAG_W-2:0], ge};
        rrem_q[g]  <= ge ? DV_W'(trial - {1'b0, rdiv_q[g-1]}) : trial[DV_W-1:0];
        rdiv_q[g]  <= rdiv_q[g-1];
        rsat_q[g]  <= rsat_q[g-1];
        rside_q[g] <= rside_q[g-1];
      end
    end
  end

  // stage h: resistance partial products and ratio - 1
  logic [RMAG_W-1:0]  rmag;
  logic [M_W-1:0]     one;
  logic [M_W-1:0]     m_d;
  tdc_rtd_pkg::side_t side_h_d;

  always_comb begin
    rmag     = rsat_q[RMAG_W] ? '1 : rpack_q[RMAG_W];
    one      = M_W'(1) << RF;
    side_h_d = rside_q[RMAG_W];
    if (side_h_d.rneg) begin
      m_d           = M_W'(rmag) + one;
      side_h_d.tneg = 1'b1;
    end else if (M_W'(rmag) >= one) begin
      m_d           = M_W'(rmag) - one;
      side_h_d.tneg = 1'b0;
    end else begin
      m_d           = one - M_W'(rmag);
      side_h_d.tneg = 1'b1;
    end
    side_h_d.big   = m_d >= (M_W'(1) << BIG_SH);
    side_h_d.mzero = (m_d == '0);
  end

  logic                         vh_q;
  logic [RF+RREF_W-1:0]         plo_h_q;
  logic [RMAG_W-RF+RREF_W-1:0]  phi_h_q;
  logic [BIG_SH-1:0]            m_h_q;
  tdc_rtd_pkg::side_t           side_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en) vh_q <= rv_q[RMAG_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_h_q  <= (RF+RREF_W)'(rmag[RF-1:0]) * (RF+RREF_W)'(ref_res_q);
      phi_h_q  <= (RMAG_W-RF+RREF_W)'(rmag[RMAG_W-1:RF]) * (RMAG_W-RF+RREF_W)'(ref_res_q);
      m_h_q    <= m_d[BIG_SH-1:0];
      side_h_q <= side_h_d;
    end
  end

  // stage i: rounded resistance, scaling partial products
  logic [PR_W-1:0]     prod;
  logic [PR_W-RF-1:0]  r_full;
  tdc_rtd_pkg::side_t  side_i_d;

  always_comb begin
    prod     = {1'b0, phi_h_q, {RF{1'b0}}} + PR_W'(plo_h_q) + (PR_W'(1) << (RF - 1));
    r_full   = prod[PR_W-1:RF];
    side_i_d = side_h_q;
    if (side_h_q.rneg) side_i_d.rtd = '0;
    else if (r_full > (PR_W-RF)'(tdc_rtd_pkg::RTD_MAX)) side_i_d.rtd = tdc_rtd_pkg::RTD_MAX;
    else side_i_d.rtd = r_full[RTD_W-1:0];
  end

  logic                   vi_q;
  logic [ML_W+DECI_W-1:0] ml_i_q;
  logic [MH_W+DECI_W-1:0] mh_i_q;
  tdc_rtd_pkg::side_t     side_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else if (en) vi_q <= vh_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ml_i_q   <= (ML_W+DECI_W)'(m_h_q[ML_W-1:0]) * (ML_W+DECI_W)'(tdc_rtd_pkg::DECI_PER_PPM);
      mh_i_q   <= (MH_W+DECI_W)'(m_h_q[BIG_SH-1:ML_W])
                  * (MH_W+DECI_W)'(tdc_rtd_pkg::DECI_PER_PPM);
      side_i_q <= side_i_d;
    end
  end

  // temperature divider by alpha: index 0 sums the partial products
  logic [BIG_SH+DECI_W-1:0] msum;

  assign msum = {mh_i_q, {ML_W{1'b0}}} + (BIG_SH+DECI_W)'(ml_i_q);

  logic [S_W-1:0]     tpack_q [S_W+1];
  logic [ALPHA_W-1:0] trem_q  [S_W+1];
  tdc_rtd_pkg::side_t tside_q [S_W+1];
  logic               tv_q    [S_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tv_q[0] <= 1'b0;
    else if (en) tv_q[0] <= vi_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tpack_q[0] <= msum[BIG_SH+DECI_W-1:RF-1];
      trem_q[0]  <= '0;
      tside_q[0] <= side_i_q;
    end
  end

  for (genvar g = 1; g <= S_W; g++) begin : g_tdiv
    logic [ALPHA_W:0] trial;
    logic             ge;

    assign trial = {trem_q[g-1], tpack_q[g-1][S_W-1]};
    assign ge    = trial >= {1'b0, alpha_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) tv_q[g] <= 1'b0;
      else if (en) tv_q[g] <= tv_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        tpack_q[g] <= {tpack_q[g-1][S_W-2:0], ge};
        trem_q[g]  <= ge ? ALPHA_W'(trial - {1'b0, alpha_q}) : trial[ALPHA_W-1:0];
        tside_q[g] <= tside_q[g-1];
      end
    end
  end

  // stage k: round, clamp, assemble the result item
  logic [S_W:0]              mag_sum;
  logic [S_W-1:0]            mag;
  logic signed [TEMP_W-1:0]  temp;
  tdc_rtd_pkg::side_t        fin;
  logic [OTOF_W-1:0]         o_tof_ref;
  logic [OTOF_W-1:0]         o_tof5;
  logic [RTD_W-1:0]          o_rtd;
  logic [TEMP_W-1:0]         o_temp;
  logic [OUT_TW-1:0]         tdata_d;

  always_comb begin
    fin     = tside_q[S_W];
    mag_sum = {1'b0, tpack_q[S_W]} + (S_W+1)'(1);
    mag     = mag_sum[S_W:1];
    if (fin.mzero) begin
      temp = '0;
    end else if (alpha_q == '0 || fin.big) begin
      temp = fin.tneg ? TEMP_W'(-tdc_rtd_pkg::TEMP_LO) : TEMP_W'(tdc_rtd_pkg::TEMP_HI);
    end else if (fin.tneg) begin
      temp = (mag > S_W'(tdc_rtd_pkg::TEMP_LO)) ? TEMP_W'(-tdc_rtd_pkg::TEMP_LO)
                                                : -$signed(TEMP_W'(mag));
    end else begin
      temp = (mag > S_W'(tdc_rtd_pkg::TEMP_HI)) ? TEMP_W'(tdc_rtd_pkg::TEMP_HI)
                                                : $signed(TEMP_W'(mag));
    end

    o_tof_ref = fin.tof_ref;
    o_tof5    = fin.tof_stop5;
    o_rtd     = fin.rtd;
    o_temp    = temp;
    case (fin.err)
      tdc_rtd_pkg::ERR_SPAN: begin
        o_tof_ref = '0;
        o_tof5    = '0;
        o_rtd     = '0;
        o_temp    = '0;
      end
      tdc_rtd_pkg::ERR_IV: begin
        o_rtd  = '0;
        o_temp = '0;
      end
      default: begin
        o_rtd = fin.rtd;
      end
    endcase
    tdata_d = OUT_TW'({fin.err, o_temp, o_rtd, o_tof5, o_tof_ref});
  end

  logic [OUT_TW-1:0] tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= tv_q[S_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) tdata_q <= tdata_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;

endmodule

@@ sv/tdc_rtd_tof.sv @@
// time of flight pipeline: products, shared-divisor long division and rounding
`timescale 1ns / 1ps
module tdc_rtd_tof (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  tdc_rtd_pkg::meas_t                 meas_i,
  input  logic [tdc_rtd_pkg::CP_W-1:0]       cal_periods_i,
  input  logic [tdc_rtd_pkg::CLK_W-1:0]      clock_period_i,
  output logic                               valid_o,
  output tdc_rtd_pkg::tof_t                  tof_o
);

  localparam int FB    = tdc_rtd_pkg::FINE_BITS;
  localparam int CB    = tdc_rtd_pkg::COARSE_BITS;
  localparam int CP_W  = tdc_rtd_pkg::CP_W;
  localparam int PD_W  = tdc_rtd_pkg::PD_W;
  localparam int N_W   = tdc_rtd_pkg::N_W;
  localparam int CC_W  = tdc_rtd_pkg::CC_W;
  localparam int TOF_W = tdc_rtd_pkg::TOF_W;

  // stage a: differences and signs
  logic signed [FB:0] span;
  logic [FB-1:0]      span_mag;
  logic [2:0][FB:0]   d_diff;
  logic [2:0][FB-1:0] d_mag;
  logic [2:0]         d_neg;
  logic               pm_neg;
  logic               err_d;

  always_comb begin
    span     = $signed({1'b0, meas_i.cal_second}) - $signed({1'b0, meas_i.cal_first});
    span_mag = span[FB] ? FB'(-span) : span[FB-1:0];
    pm_neg   = (cal_periods_i == '0);
    err_d    = (span == '0) || (cal_periods_i == CP_W'(1));
    for (int l = 0; l < 3; l++) begin
      d_diff[l] = {1'b0, meas_i.start} - {1'b0, meas_i.stop_fine[l]};
      d_mag[l]  = d_diff[l][FB] ? FB'(-d_diff[l]) : d_diff[l][FB-1:0];
      d_neg[l]  = d_diff[l][FB] ^ pm_neg ^ span[FB];
    end
  end

  logic               va_q;
  logic [2:0][FB-1:0] dmag_a_q;
  logic [2:0]         neg_a_q;
  logic [FB-1:0]      s_a_q;
  logic [2:0][CB-1:0] coarse_a_q;
  logic               err_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_a_q   <= d_mag;
      neg_a_q    <= d_neg;
      s_a_q      <= span_mag;
      coarse_a_q <= meas_i.coarse;
      err_a_q    <= err_d;
    end
  end

  // stage b: products with the clock period
  logic                 vb_q;
  logic [2:0][PD_W-1:0] pd_b_q;
  logic [2:0][CC_W-1:0] cc_b_q;
  logic [2:0]           neg_b_q;
  logic [FB-1:0]        s_b_q;
  logic                 err_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        pd_b_q[l] <= PD_W'(dmag_a_q[l]) * PD_W'(clock_period_i);
        cc_b_q[l] <= CC_W'(coarse_a_q[l]) * CC_W'(clock_period_i);
      end
      neg_b_q <= neg_a_q;
      s_b_q   <= s_a_q;
      err_b_q <= err_a_q;
    end
  end

  // stage c: times |cal_periods - 1|, loads the divider
  logic [2:0][N_W-1:0]  pack_q [N_W+1];
  logic [2:0][FB-1:0]   rem_q  [N_W+1];
  logic [2:0][CC_W-1:0] cc_q   [N_W+1];
  logic [2:0]           neg_q  [N_W+1];
  logic [FB-1:0]        s_q    [N_W+1];
  logic                 err_q  [N_W+1];
  logic                 v_q    [N_W+1];
  logic [CP_W-1:0]      pm_mag;

  assign pm_mag = (cal_periods_i == '0) ? CP_W'(1) : cal_periods_i - CP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        pack_q[0][l] <= N_W'(pd_b_q[l]) * N_W'(pm_mag);
      end
      rem_q[0] <= '0;
      cc_q[0]  <= cc_b_q;
      neg_q[0] <= neg_b_q;
      s_q[0]   <= s_b_q;
      err_q[0] <= err_b_q;
    end
  end

  // one quotient bit per stage, three lanes share the divisor
  for (genvar g = 1; g <= N_W; g++) begin : g_div
    logic [2:0][FB:0] trial;
    logic [2:0]       ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_q[g-1][l], pack_q[g-1][l][N_W-1]};
        ge[l]    = trial[l] >= {1'b0, s_q[g-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[g] <= 1'b0;
      else if (en_i) v_q[g] <= v_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          pack_q[g][l] <= {pack_q[g-1][l][N_W-2:0], ge[l]};
          rem_q[g][l]  <= ge[l] ? FB'(trial[l] - {1'b0, s_q[g-1]}) : trial[l][FB-1:0];
        end
        cc_q[g]  <= cc_q[g-1];
        neg_q[g] <= neg_q[g-1];
        s_q[g]   <= s_q[g-1];
        err_q[g] <= err_q[g-1];
      end
    end
  end

  // stage e: round half away from zero, apply sign, add the coarse part
  logic [2:0][N_W:0]       f_d;
  logic [2:0]              rnd_d;
  logic signed [TOF_W-1:0] fine_d [3];
  logic signed [TOF_W-1:0] t_d    [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd_d[l]  = {rem_q[N_W][l], 1'b0} >= {1'b0, s_q[N_W]};
      f_d[l]    = {1'b0, pack_q[N_W][l]} + (N_W+1)'(rnd_d[l]);
      fine_d[l] = neg_q[N_W][l] ? -$signed(TOF_W'(f_d[l])) : $signed(TOF_W'(f_d[l]));
      t_d[l]    = $signed(TOF_W'(cc_q[N_W][l])) + fine_d[l];
    end
  end

  logic              ve_q;
  tdc_rtd_pkg::tof_t tof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en_i) ve_q <= v_q[N_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tof_q.err_span <= err_q[N_W];
      tof_q.t1       <= t_d[0];
      tof_q.t4       <= t_d[1];
      tof_q.t5       <= t_d[2];
    end
  end

  assign valid_o = ve_q;
  assign tof_o   = tof_q;

endmodule

@@ sv/tdc_rtd_checker.sv @@
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
module tdc_rtd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tdc_rtd_pkg::OUT_TW-1:0] m_axis_tdata
);

  logic [1:0]  err;
  logic [32:0] tof_ref;
  logic [32:0] tof5;
  logic [26:0] rtd;

  assign tof_ref = m_axis_tdata[32:0];
  assign tof5    = m_axis_tdata[65:33];
  assign rtd     = m_axis_tdata[92:66];
  assign err     = m_axis_tdata[109:108];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> err != 2'd3)
    else $error("undefined error code");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err == tdc_rtd_pkg::ERR_SPAN |-> m_axis_tdata[107:0] == '0)
    else $error("span error with non-zero fields");

  a_iv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err == tdc_rtd_pkg::ERR_IV |-> m_axis_tdata[107:66] == '0)
    else $error("interval error with non-zero rtd or temperature");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> tof_ref <= tdc_rtd_pkg::TOF_MAX && tof5 <= tdc_rtd_pkg::TOF_MAX
                      && rtd <= tdc_rtd_pkg::RTD_MAX)
    else $error("saturation limit exceeded");

endmodule

bind tdc_rtd_temperature_compute tdc_rtd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
